[sv/hcd_pkg.sv]
`default_nettype none

package hcd_pkg;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;

	localparam logic [31:0] SIZE_CAP    = 32'h8000_0000;
	localparam logic [31:0] SIZE_MAX    = 32'h7FFF_FFFF;
	localparam logic [31:0] DIGIT_LIMIT = SIZE_CAP >> 4;
	localparam logic [1:0]  TRAIL_BYTES = 2'd2;

	typedef enum logic [5:0] {
		PH_BLANKS = 6'b000001,
		PH_SIGNED = 6'b000010,
		PH_ZERO   = 6'b000100,
		PH_PREFIX = 6'b001000,
		PH_DIGITS = 6'b010000,
		PH_DONE   = 6'b100000
	} phase_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_END     = 1'b1
	} kind_t;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] acc;
		logic        neg;
	} parse_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} result_t;

	// {valid, value} of a hex character
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[sv/hcd_if.sv]
`default_nettype none

interface hcd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface hcd_out_if;
	logic       valid;
	logic       ready;
	logic       out_kind;
	logic [7:0] out_byte;
	modport source (output valid, output out_kind, output out_byte, input ready);
	modport sink (input valid, input out_kind, input out_byte, output ready);
endinterface

interface hcd_cfg_if;
	logic valid;
	logic ready;
	logic chunked_enable;
	modport source (output valid, output chunked_enable, input ready);
	modport sink (input valid, input chunked_enable, output ready);
endinterface

`default_nettype wire

[sv/hcd_line_parse.sv]
`default_nettype none

// Next state of the size-line scanner for one character.
module hcd_line_parse (
	input  hcd_pkg::parse_t    cur,
	input  logic [7:0]         c,
	output hcd_pkg::parse_t    nxt
);
	import hcd_pkg::*;

	logic [4:0]  hx;
	logic [31:0] grown;
	logic        blank;
	parse_t      start;

	always_comb begin
		hx    = hex_digit(c);
		grown = (cur.acc >= DIGIT_LIMIT) ? SIZE_CAP : {cur.acc[27:0], hx[3:0]};
		blank = (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);

		// first character after blanks and sign
		start = cur;
		if (c == CH_ZERO) begin
			start.phase = PH_ZERO;
		end else if (hx[4]) begin
			start.acc   = grown;
			start.phase = PH_DIGITS;
		end else begin
			start.phase = PH_DONE;
		end

		nxt = cur;
		unique case (cur.phase)
			PH_BLANKS: begin
				if (blank) begin
					nxt = cur;
				end else if (c == CH_PLUS || c == CH_MINUS) begin
					nxt.neg   = (c == CH_MINUS);
					nxt.phase = PH_SIGNED;
				end else begin
					nxt = start;
				end
			end
			PH_SIGNED: nxt = start;
			PH_ZERO: begin
				if (c == CH_X_LO || c == CH_X_UP) begin
					nxt.phase = PH_PREFIX;
				end else if (hx[4]) begin
					nxt.acc   = grown;
					nxt.phase = PH_DIGITS;
				end else begin
					nxt.phase = PH_DONE;
				end
			end
			PH_PREFIX, PH_DIGITS: begin
				if (hx[4]) begin
					nxt.acc   = grown;
					nxt.phase = PH_DIGITS;
				end else begin
					nxt.phase = PH_DONE;
				end
			end
			PH_DONE: nxt.phase = PH_DONE;
			default: nxt.phase = PH_DONE;
		endcase
	end

endmodule

`default_nettype wire

[sv/hcd_out_buf.sv]
`default_nettype none

// Two-word result queue: two slots written and read in turn.
module hcd_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  hcd_pkg::result_t   push_data,
	output logic               space,
	hcd_out_if.source          result
);
	import hcd_pkg::*;

	result_t    slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;
	result_t    head;

	assign space  = (cnt_q != 2'd2);
	assign pop    = result.valid && result.ready;
	assign head   = slot_q[rd_q];

	assign result.valid    = (cnt_q != 2'd0);
	assign result.out_kind = head.kind;
	assign result.out_byte = head.data;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[sv/http_chunked_decoder.sv]
`default_nettype none

// HTTP/1.1 chunked body decoder. Takes one body byte per clock and gives at most one result
// word per byte: a payload byte, or an end marker when a zero-size chunk line ends. With
// chunked_enable low every byte passes straight through. With it high, size lines are read
// as hex (leading blanks, sign, optional 0x, stop at the first non-hex character; only the
// first LINE_CHARS-1 characters of a line count), the size takes effect on LF, that many
// bytes are passed and the two bytes after them dropped. Sizes saturate at 31 bits. Each
// byte is fully handled in the cycle it is taken, so the input sustains one byte per cycle;
// a two-word result queue lets it keep going while a result waits, and ready drops only
// when both words are held. Each result word is registered in the queue before it is offered.
module http_chunked_decoder #(
	parameter int LINE_CHARS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	hcd_in_if.sink     body,
	hcd_out_if.source  result,
	hcd_cfg_if.sink    cfg
);
	import hcd_pkg::*;

	localparam int LEN_W = $clog2(LINE_CHARS);
	localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_CHARS - 1);

	logic             en_q;
	logic [31:0]      rem_q;
	logic [1:0]       trail_q;
	logic [LEN_W-1:0] len_q;
	parse_t           line_q;
	parse_t           line_nxt;

	logic             take;
	logic             space;
	logic             header;
	logic             push;
	result_t          push_data;
	logic [31:0]      size_new;

	hcd_line_parse u_parse (
		.cur (line_q),
		.c   (body.in_byte),
		.nxt (line_nxt)
	);

	hcd_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.space     (space),
		.result    (result)
	);

	assign body.ready = space;
	assign cfg.ready  = 1'b1;
	assign take       = body.valid && body.ready;
	assign header     = (rem_q == 32'd0) || rem_q[31];

	always_comb begin
		if (line_q.neg) begin
			size_new = 32'd0 - line_q.acc;
		end else begin
			size_new = line_q.acc[31] ? SIZE_MAX : line_q.acc;
		end
	end

	always_comb begin
		push           = 1'b0;
		push_data.kind = KIND_PAYLOAD;
		push_data.data = body.in_byte;
		if (take) begin
			if (!en_q) begin
				push = 1'b1;
			end else if (trail_q == 2'd0) begin
				if (header) begin
					if (body.in_byte == CH_LF && line_q.acc == 32'd0) begin
						push           = 1'b1;
						push_data.kind = KIND_END;
						push_data.data = 8'd0;
					end
				end else begin
					push = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q         <= 1'b0;
			rem_q        <= '1;
			trail_q      <= 2'd0;
			len_q        <= '0;
			line_q.phase <= PH_BLANKS;
			line_q.acc   <= 32'd0;
			line_q.neg   <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				en_q <= cfg.chunked_enable;
			end
			if (take && en_q) begin
				if (trail_q != 2'd0) begin
					trail_q <= trail_q - 2'd1;
				end else if (header) begin
					if (body.in_byte == CH_LF) begin
						rem_q        <= size_new;
						len_q        <= '0;
						line_q.phase <= PH_BLANKS;
						line_q.acc   <= 32'd0;
						line_q.neg   <= 1'b0;
					end else if (len_q < LEN_LAST) begin
						len_q  <= len_q + LEN_W'(1);
						line_q <= line_nxt;
					end
				end else begin
					rem_q <= rem_q - 32'd1;
					if (rem_q == 32'd1) begin
						trail_q <= TRAIL_BYTES;
					end
				end
			end
		end
	end

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.out_kind) |-> (result.out_byte == 8'd0))
		else $error("end marker carries a nonzero byte");

	a_trail_after_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		(trail_q != 2'd0) |-> (rem_q == 32'd0))
		else $error("trailer pending while chunk bytes remain");

	a_line_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_LAST)
		else $error("size line length overran");

	a_acc_cap: assert property (@(posedge clk) disable iff (!arst_n)
		line_q.acc <= SIZE_CAP)
		else $error("size accumulator above saturation value");

endmodule

`default_nettype wire

[tb/http_chunked_decoder_tb.sv]
module http_chunked_decoder_tb;
	import hcd_pkg::*;

	localparam int LINE_CHARS   = 32;
	localparam int RANDOM_BYTES = 1300;
	localparam int CYCLE_LIMIT  = 500000;

	typedef struct packed {
		logic       en;
		logic [7:0] data;
		logic       typed;
		logic       emits;
		result_t    word;
	} probe_t;

	logic clk = 1'b0;
	logic arst_n;

	hcd_in_if  body_if ();
	hcd_out_if result_if ();
	hcd_cfg_if cfg_if ();

	http_chunked_decoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.body   (body_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	always #10 clk = ~clk;

	// decoder state as predicted
	logic        chunked_on;
	logic [31:0] chunk_left;
	logic [1:0]  trail_left;
	int          line_chars;
	logic [31:0] size_acc;
	phase_t      size_phase;
	logic        size_neg;

	result_t pending_words [$];
	int      errors = 0;
	int      cycle_count = 0;
	int      fed = 0;
	bit      src_burst = 1'b0;
	bit      snk_burst = 1'b0;

	// expectation typed into the table travels beside the word being sent
	logic    row_typed;
	logic    row_emits;
	result_t row_word;

	logic [7:0] blanks [5] = '{CH_SP, CH_TAB, 8'h0B, 8'h0C, CH_CR};

	probe_t probes [25] = '{
		'{1'b0, 8'h00,    1'b1, 1'b1, '{KIND_PAYLOAD, 8'h00}},
		'{1'b0, 8'hFF,    1'b1, 1'b1, '{KIND_PAYLOAD, 8'hFF}},
		'{1'b1, CH_SP,    1'b0, 1'b0, '0},
		'{1'b1, "1",      1'b0, 1'b0, '0},
		'{1'b1, ";",      1'b0, 1'b0, '0},
		'{1'b1, "x",      1'b0, 1'b0, '0},
		'{1'b1, CH_LF,    1'b1, 1'b0, '0},
		'{1'b1, 8'h00,    1'b0, 1'b0, '0},
		'{1'b1, CH_CR,    1'b1, 1'b0, '0},
		'{1'b1, CH_LF,    1'b1, 1'b0, '0},
		'{1'b1, CH_MINUS, 1'b0, 1'b0, '0},
		'{1'b1, "5",      1'b0, 1'b0, '0},
		'{1'b1, CH_LF,    1'b1, 1'b0, '0},
		'{1'b1, CH_ZERO,  1'b0, 1'b0, '0},
		'{1'b1, CH_X_LO,  1'b0, 1'b0, '0},
		'{1'b1, CH_LF,    1'b1, 1'b1, '{KIND_END, 8'h00}},
		'{1'b1, CH_LF,    1'b1, 1'b1, '{KIND_END, 8'h00}},
		'{1'b1, CH_PLUS,  1'b0, 1'b0, '0},
		'{1'b1, CH_LF,    1'b1, 1'b1, '{KIND_END, 8'h00}},
		'{1'b1, "2",      1'b0, 1'b0, '0},
		'{1'b1, CH_LF,    1'b1, 1'b0, '0},
		'{1'b1, 8'hFF,    1'b0, 1'b0, '0},
		'{1'b1, 8'h7E,    1'b0, 1'b0, '0},
		'{1'b1, CH_LF,    1'b1, 1'b0, '0},
		'{1'b1, "1",      1'b1, 1'b0, '0}
	};

	function automatic void restart_line();
		line_chars = 0;
		size_acc   = '0;
		size_phase = PH_BLANKS;
		size_neg   = 1'b0;
	endfunction

	function automatic void push_digit(input logic [3:0] d);
		if (size_acc >= DIGIT_LIMIT) begin
			size_acc = SIZE_CAP;
		end else begin
			size_acc = {size_acc[27:0], d};
		end
		if (size_acc > SIZE_CAP) begin
			size_acc = SIZE_CAP;
		end
	endfunction

	// strtol-style hex scan, one character at a time
	function automatic void scan_char(input logic [7:0] c);
		logic       is_hex;
		logic [3:0] val;
		is_hex = 1'b1;
		val = '0;
		if (c >= "0" && c <= "9") begin
			val = 4'(c - "0");
		end else if (c >= "a" && c <= "f") begin
			val = 4'(c - "a" + 8'd10);
		end else if (c >= "A" && c <= "F") begin
			val = 4'(c - "A" + 8'd10);
		end else begin
			is_hex = 1'b0;
		end
		if (size_phase == PH_BLANKS) begin
			if (c == CH_SP || (c >= 8'd9 && c <= 8'd13)) begin
				return;
			end
			if (c == CH_PLUS || c == CH_MINUS) begin
				size_neg = (c == CH_MINUS);
				size_phase = PH_SIGNED;
				return;
			end
			// no sign: carry on as if one had been seen
			size_phase = PH_SIGNED;
		end
		case (size_phase)
			PH_SIGNED: begin
				if (c == CH_ZERO) begin
					size_phase = PH_ZERO;
				end else if (is_hex) begin
					push_digit(val);
					size_phase = PH_DIGITS;
				end else begin
					size_phase = PH_DONE;
				end
			end
			PH_ZERO: begin
				if (c == CH_X_LO || c == CH_X_UP) begin
					size_phase = PH_PREFIX;
				end else if (is_hex) begin
					push_digit(val);
					size_phase = PH_DIGITS;
				end else begin
					size_phase = PH_DONE;
				end
			end
			PH_PREFIX, PH_DIGITS: begin
				if (is_hex) begin
					push_digit(val);
					size_phase = PH_DIGITS;
				end else begin
					size_phase = PH_DONE;
				end
			end
			default: size_phase = PH_DONE;
		endcase
	endfunction

	function automatic void decode_byte(input logic [7:0] c, output logic emits,
			output result_t word);
		emits = 1'b0;
		word = '0;
		if (!chunked_on) begin
			emits = 1'b1;
			word = '{KIND_PAYLOAD, c};
			return;
		end
		if (trail_left != 2'd0) begin
			trail_left = trail_left - 2'd1;
			return;
		end
		if (chunk_left == '0 || chunk_left[31]) begin
			if (c == CH_LF) begin
				if (size_neg) begin
					chunk_left = 32'd0 - size_acc;
				end else begin
					chunk_left = (size_acc > SIZE_MAX) ? SIZE_MAX : size_acc;
				end
				restart_line();
				if (chunk_left == '0) begin
					emits = 1'b1;
					word = '{KIND_END, 8'h00};
				end
			end else if (line_chars < LINE_CHARS - 1) begin
				line_chars++;
				scan_char(c);
			end
			return;
		end
		chunk_left = chunk_left - 32'd1;
		if (chunk_left == '0) begin
			trail_left = TRAIL_BYTES;
		end
		emits = 1'b1;
		word = '{KIND_PAYLOAD, c};
	endfunction

	function automatic int draw_gap(inout bit burst);
		if ($urandom_range(0, 39) == 0) begin
			burst = !burst;
		end
		return burst ? 0 : int'($urandom_range(0, 14));
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) begin
			return CH_ZERO + 8'(v);
		end
		return ($urandom_range(0, 1) ? "A" : "a") + 8'(v) - 8'd10;
	endfunction

	always @(posedge clk) begin
		logic    emits;
		result_t word;
		result_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("http_chunked_decoder verification failed");
			$finish;
		end else begin
			if (result_if.valid && result_if.ready) begin
				if (pending_words.size() == 0) begin
					$display("%0t: expected no word, got kind %0d byte %02h", $time,
						result_if.out_kind, result_if.out_byte);
					errors++;
				end else begin
					want = pending_words.pop_front();
					if (result_if.out_kind !== want.kind || result_if.out_byte !== want.data) begin
						$display("%0t: expected kind %0d byte %02h, got kind %0d byte %02h",
							$time, want.kind, want.data, result_if.out_kind,
							result_if.out_byte);
						errors++;
					end
				end
			end
			if (cfg_if.valid && cfg_if.ready) begin
				chunked_on = cfg_if.chunked_enable;
			end
			if (body_if.valid && body_if.ready) begin
				decode_byte(body_if.in_byte, emits, word);
				if (row_typed) begin
					emits = row_emits;
					word = row_word;
				end
				if (emits) begin
					pending_words.push_back(word);
				end
			end
		end
	end

	// result side: random stalls per word
	initial begin
		int stall;
		result_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_gap(snk_burst);
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!result_if.valid);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic typed, input logic emits,
			input result_t w);
		int gap;
		gap = draw_gap(src_burst);
		if (gap > 0) begin
			body_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		body_if.valid   <= 1'b1;
		body_if.in_byte <= b;
		row_typed       <= typed;
		row_emits       <= emits;
		row_word        <= w;
		do @(posedge clk); while (!body_if.ready);
		fed++;
	endtask

	task automatic feed(input logic [7:0] b);
		send_byte(b, 1'b0, 1'b0, '0);
	endtask

	// hold off until every expected word is out, then wait on for dropped bytes
	task automatic settle();
		body_if.valid <= 1'b0;
		do @(posedge clk); while (pending_words.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mode(input logic v);
		cfg_if.valid          <= 1'b1;
		cfg_if.chunked_enable <= v;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic feed_hex(input logic [31:0] v, input int digits);
		for (int i = digits - 1; i >= 0; i--) begin
			feed(hex_char(4'(v >> (4 * i))));
		end
	endtask

	task automatic end_line();
		if ($urandom_range(0, 4) != 0) begin
			feed(CH_CR);
		end
		feed(CH_LF);
	endtask

	// pass-through stretch; decoder state must survive it untouched
	task automatic bypass_burst();
		settle();
		write_mode(1'b0);
		repeat ($urandom_range(5, 30)) feed(8'($urandom_range(0, 255)));
		settle();
		write_mode(1'b1);
	endtask

	task automatic send_chunk();
		int n;
		int split;
		n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(17, 80))
			: int'($urandom_range(1, 16));
		repeat ($urandom_range(0, 2)) feed(blanks[$urandom_range(0, 4)]);
		if ($urandom_range(0, 5) == 0) begin
			feed(CH_PLUS);
		end
		if ($urandom_range(0, 4) == 0) begin
			feed(CH_ZERO);
			feed($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
		end
		feed_hex(32'(n), ((n > 15) ? 2 : 1) + int'($urandom_range(0, 2)));
		if ($urandom_range(0, 3) == 0) begin
			feed(";");
			repeat ($urandom_range(0, 6)) feed(8'($urandom_range(33, 126)));
		end
		end_line();
		split = (n > 1 && $urandom_range(0, 11) == 0) ? int'($urandom_range(1, n - 1)) : -1;
		for (int i = 0; i < n; i++) begin
			if (i == split) begin
				bypass_burst();
			end
			feed(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 3) == 0) begin
			repeat (2) feed(8'($urandom_range(0, 255)));
		end else begin
			feed(CH_CR);
			feed(CH_LF);
		end
	endtask

	task automatic send_zero_line();
		case ($urandom_range(0, 5))
			0: feed(CH_ZERO);
			1: begin
				feed(CH_PLUS);
				feed(CH_ZERO);
				feed(";");
				feed("x");
			end
			2: feed(blanks[$urandom_range(0, 4)]);
			3: begin
				feed(CH_MINUS);
				feed(CH_ZERO);
			end
			4: begin
				feed(CH_ZERO);
				feed(CH_X_UP);
			end
			default: ;
		endcase
		end_line();
	endtask

	task automatic send_negative_line();
		feed(CH_MINUS);
		if ($urandom_range(0, 3) == 0) begin
			feed_hex(SIZE_CAP, 8);
		end else begin
			repeat ($urandom_range(1, 12)) feed(hex_char(4'($urandom_range(0, 15))));
		end
		end_line();
	endtask

	// the digit lands either side of the character limit; "zz" then reads as payload
	// of a two-byte chunk or as a digitless line, and both stay in step
	task automatic send_long_line();
		repeat ($urandom_range(26, 34)) feed(blanks[$urandom_range(0, 4)]);
		feed("2");
		feed(CH_LF);
		feed("z");
		feed("z");
		feed(CH_CR);
		feed(CH_LF);
	endtask

	task automatic send_noise_line();
		logic [7:0] c;
		feed("g");
		repeat ($urandom_range(2, 12)) begin
			c = 8'($urandom_range(0, 255));
			feed((c == CH_LF) ? 8'h71 : c);
		end
		feed(CH_LF);
	endtask

	initial begin
		logic en_now;
		int   pick;
		arst_n = 1'b0;
		body_if.valid         <= 1'b0;
		body_if.in_byte       <= 8'h00;
		cfg_if.valid          <= 1'b0;
		cfg_if.chunked_enable <= 1'b0;
		row_typed             <= 1'b0;
		row_emits             <= 1'b0;
		row_word              <= '0;
		chunked_on = 1'b0;
		chunk_left = '1;
		trail_left = '0;
		restart_line();
		en_now = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probes[i]) begin
			if (probes[i].en != en_now) begin
				settle();
				write_mode(probes[i].en);
				en_now = probes[i].en;
			end
			send_byte(probes[i].data, probes[i].typed, probes[i].emits, probes[i].word);
		end
		settle();

		fed = 0;
		while (fed < RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				send_chunk();
			end else if (pick < 70) begin
				send_zero_line();
			end else if (pick < 78) begin
				send_negative_line();
			end else if (pick < 84) begin
				send_long_line();
			end else if (pick < 92) begin
				send_noise_line();
			end else if (pick < 96) begin
				bypass_burst();
			end else begin
				settle();
			end
		end

		// oversize chunk goes last: it clamps to the 31-bit limit and never finishes
		repeat (10) feed(hex_char(4'hF));
		end_line();
		repeat (20) feed(8'($urandom_range(0, 255)));
		settle();

		if (errors == 0) begin
			$display("http_chunked_decoder verification clean");
		end else begin
			$display("http_chunked_decoder verification failed");
		end
		$finish;
	end

endmodule
